// File: hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box cull package
// Shared widths, register map and the item type passed along the cell row.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int unsigned NUM_PLANES = 4;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned COORD_W    = 16;
    localparam int unsigned COMP_W     = 16;
    localparam int unsigned NORMAL_W   = NUM_AXES * COMP_W;
    localparam int unsigned DIST_W     = 40;
    localparam int unsigned PROD_W     = COORD_W + COMP_W;
    localparam int unsigned SUM_W      = DIST_W + 2;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = NORMAL_W;
    localparam int unsigned NUM_REGS   = 2 * NUM_PLANES;

    // Register map: each plane owns a normal register followed by a distance register.
    localparam logic CFG_KIND_NORMAL   = 1'b0;
    localparam logic CFG_KIND_DISTANCE = 1'b1;

    typedef logic [NUM_AXES-1:0][COORD_W-1:0] t_coords;

    typedef struct packed {
        t_coords                 box_min;
        t_coords                 box_max;
        logic [NUM_PLANES-1:0]   mask;
        logic                    culled;
    } t_item;

endpackage

// File: hdl/fbc_cell.sv
// ----------------------------------------------------------------------------
// Frustum box cull plane cell
// Tests one item against one plane in two stages: corner products, then sums.
// ----------------------------------------------------------------------------
module fbc_cell #(
    parameter int unsigned PLANE = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  fbc_pkg::t_item                      i_item,
    input  logic [fbc_pkg::NORMAL_W-1:0]        i_normal,
    input  logic signed [fbc_pkg::DIST_W-1:0]   i_distance,
    output logic                                o_valid,
    output fbc_pkg::t_item                      o_item
);
    import fbc_pkg::*;

    logic                     r_a_valid;
    logic                     r_a_act;
    t_item                    r_a_item;
    logic signed [PROD_W-1:0] r_a_far  [NUM_AXES];
    logic signed [PROD_W-1:0] r_a_near [NUM_AXES];

    logic                     n_a_act;
    logic signed [PROD_W-1:0] n_a_far  [NUM_AXES];
    logic signed [PROD_W-1:0] n_a_near [NUM_AXES];

    logic                     r_b_valid;
    t_item                    r_b_item;
    t_item                    n_b_item;

    logic signed [SUM_W-1:0]  far_sum;
    logic signed [SUM_W-1:0]  near_sum;

    always_comb begin
        logic signed [COMP_W-1:0]  comp;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] far_c;
        logic signed [COORD_W-1:0] near_c;
        n_a_act = !i_item.culled && i_item.mask[PLANE];
        for (int a = 0; a < NUM_AXES; a++) begin
            comp   = $signed(i_normal[a*COMP_W +: COMP_W]);
            lo     = $signed(i_item.box_min[a]);
            hi     = $signed(i_item.box_max[a]);
            far_c  = (comp > 0) ? hi : lo;
            near_c = (comp < 0) ? hi : lo;
            n_a_far[a]  = far_c * comp;
            n_a_near[a] = near_c * comp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_act  <= n_a_act;
            r_a_item <= i_item;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_a_far[a]  <= n_a_far[a];
                r_a_near[a] <= n_a_near[a];
            end
        end
    end

    always_comb begin
        far_sum  = SUM_W'(i_distance) + SUM_W'(r_a_far[0]) + SUM_W'(r_a_far[1])
                 + SUM_W'(r_a_far[2]);
        near_sum = SUM_W'(i_distance) + SUM_W'(r_a_near[0]) + SUM_W'(r_a_near[1])
                 + SUM_W'(r_a_near[2]);
        n_b_item = r_a_item;
        if (r_a_act) begin
            if (far_sum <= 0) begin
                n_b_item.culled = 1'b1;
            end else if (near_sum >= 0) begin
                n_b_item.mask[PLANE] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item <= n_b_item;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// File: hdl/frustum_box_cull_with_plane_mask.sv
// ----------------------------------------------------------------------------
// Frustum box cull with plane mask
// Each box item flows through a row of four plane cells, one per frustum plane,
// in plane order. A cell has two stages: the six corner products, then the two
// sums with the plane distance and the compares. The block accepts one item
// per cycle while the output is not stalled, and passes it through the two
// stages of each of the four cells. The whole row advances together, so it
// holds while a finished result waits at the output. Plane registers are
// written through the configuration channel, which is always ready; indexes
// above seven are ignored.
// ----------------------------------------------------------------------------
module frustum_box_cull_with_plane_mask (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fbc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_min_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_min_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_min_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_max_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_max_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]    i_box_max_z,
    input  logic [fbc_pkg::NUM_PLANES-1:0]        i_planes_pending,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_culled,
    output logic [fbc_pkg::NUM_PLANES-1:0]        o_planes_left
);
    import fbc_pkg::*;

    logic [NORMAL_W-1:0]      r_normal   [NUM_PLANES];
    logic signed [DIST_W-1:0] r_distance [NUM_PLANES];

    logic  en;
    logic  chain_valid [NUM_PLANES+1];
    t_item chain_item  [NUM_PLANES+1];

    assign o_cfg_ready = 1'b1;

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cfg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_normal[k]   <= '0;
                r_distance[k] <= '0;
            end else if (i_cfg_valid && (i_cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(k))) begin
                if (i_cfg_index[0] == CFG_KIND_NORMAL) begin
                    r_normal[k] <= i_cfg_data;
                end else begin
                    r_distance[k] <= $signed(i_cfg_data[DIST_W-1:0]);
                end
            end
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        chain_valid[0]          = i_in_valid;
        chain_item[0].box_min   = {i_box_min_z, i_box_min_y, i_box_min_x};
        chain_item[0].box_max   = {i_box_max_z, i_box_max_y, i_box_max_x};
        chain_item[0].mask      = i_planes_pending;
        chain_item[0].culled    = 1'b0;
    end

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_cell
        fbc_cell #(
            .PLANE (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_valid    (chain_valid[k]),
            .i_item     (chain_item[k]),
            .i_normal   (r_normal[k]),
            .i_distance (r_distance[k]),
            .o_valid    (chain_valid[k+1]),
            .o_item     (chain_item[k+1])
        );
    end

    assign o_out_valid   = chain_valid[NUM_PLANES];
    assign o_culled      = chain_item[NUM_PLANES].culled;
    assign o_planes_left = chain_item[NUM_PLANES].mask;

endmodule

// File: hdl/fbc_checker.sv
// ----------------------------------------------------------------------------
// Frustum box cull port checker
// Watches the top level ports for stall, reset and handshake behavior.
// ----------------------------------------------------------------------------
module fbc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_cfg_ready,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic                               o_culled,
    input logic [fbc_pkg::NUM_PLANES-1:0]     o_planes_left
);
    import fbc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_culled) && $stable(o_planes_left))
        else $error("Stalled result item changed or dropped.");

    a_stall_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stall.");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("Result item shown right after reset.");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("Configuration channel not ready.");

endmodule

bind frustum_box_cull_with_plane_mask fbc_checker u_fbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_culled      (o_culled),
    .o_planes_left (o_planes_left)
);
